// File: rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Types, codes and constants shared by the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int MAX_PAGES    = 4096;
   localparam int PAGE_BYTES   = 4096;
   localparam int WORD_BITS    = 32;
   localparam int BITMAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
   localparam int BIT_IDX_W    = $clog2(WORD_BITS);
   localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
   localparam int REG_W        = 13;
   localparam int ADDR_W       = 32;
   localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;

   localparam logic [2:0] FUNC_ALLOC       = 3'd0;
   localparam logic [2:0] FUNC_ALLOC_BELOW = 3'd1;
   localparam logic [2:0] FUNC_FREE        = 3'd2;
   localparam logic [2:0] FUNC_RESERVE     = 3'd3;
   localparam logic [2:0] FUNC_RELEASE     = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_MEMORY   = 3'd1;
   localparam logic [2:0] ST_MISALIGNED  = 3'd2;
   localparam logic [2:0] ST_OUT_RANGE   = 3'd3;
   localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;
   localparam logic [2:0] ST_ZERO_LIMIT  = 3'd5;

   localparam logic [1:0] CSR_PAGE_COUNT   = 2'd0;
   localparam logic [1:0] CSR_BUNDLE_START = 2'd1;
   localparam logic [1:0] CSR_BUNDLE_END   = 2'd2;

   typedef struct packed {
      logic [2:0]        func;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] length_bytes;
      logic [ADDR_W-1:0] boundary_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] page_address;
      logic [REG_W-1:0]  used_pages;
      logic [REG_W-1:0]  free_pages;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic rd;
      logic cap;
      logic step;
      logic wb;
      logic rsp;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic stop;
      logic word_end;
   } sts_type;

endpackage

// File: rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: load, check, then read / scan / write back bitmap words.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output bpfa_pkg::cmd_type cmd,
   input  bpfa_pkg::sts_type sts
);
   import bpfa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_CAP   = 3'd3;
   localparam logic [2:0] S_STEP  = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;
   localparam logic [2:0] S_RSP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       stop_ff, stop_in;

   always_comb begin
      state_in = state_ff;
      stop_in  = stop_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            stop_in   = 1'b0;
            state_in  = sts.skip ? S_RSP : S_RD;
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            cmd.cap  = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (sts.stop || sts.word_end) begin
               stop_in  = sts.stop;
               state_in = S_WB;
            end
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = stop_ff ? S_RSP : S_RD;
         end
         S_RSP: begin
            cmd.rsp  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         stop_ff  <= stop_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/bpfa_dpath.sv
// ----------------------------------------------------------------------------
// bpfa_dpath
// Bitmap word memory, word buffer, page walker, counts and registers.
// ----------------------------------------------------------------------------
module bpfa_dpath (
   input  logic              clock,
   input  logic              reset,
   input  bpfa_pkg::req_type req,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [bpfa_pkg::REG_W-1:0] csr_data,
   input  bpfa_pkg::cmd_type cmd,
   output bpfa_pkg::sts_type sts,
   output bpfa_pkg::rsp_type rsp_data
);
   import bpfa_pkg::*;

   localparam logic [ADDR_W:0] PAGE_BYTES_X = (ADDR_W+1)'(PAGE_BYTES);

   // bitmap store; entries not yet written read as the reset pattern
   logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
   logic [BITMAP_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rvalid_ff;
   logic [WORD_IDX_W-1:0] wa_ff;

   logic [REG_W-1:0] page_count_ff, bstart_ff, bend_ff;
   logic [REG_W-1:0] used_ff, used_in;
   logic [2:0]       func_ff;
   logic [ADDR_W-1:0] addr_ff, bnd_ff;
   logic [PAGE_W-1:0] p_ff, p_in;
   logic [REG_W-1:0]  lim_ff, lim_in;
   logic [ADDR_W:0]   rem_ff, rem_in;
   logic [2:0]        status_ff, status_in;
   logic [ADDR_W-1:0] paddr_ff, paddr_in;
   logic [WORD_BITS-1:0] wbuf_ff, wbuf_in;

   logic [REG_W-1:0] n;
   logic [PAGE_W-1:0] req_page;
   logic [ADDR_W+1:0] end_sum;
   logic [ADDR_W+1-PAGE_SHIFT:0] end_page;
   logic [WORD_IDX_W-1:0] widx;
   logic [BIT_IDX_W-1:0]  bidx;
   logic cur_bit, in_win, bnd_ok, misaligned;
   logic [ADDR_W:0] rem_sum;
   logic [PAGE_W:0] p_next;

   assign n = (page_count_ff > REG_W'(MAX_PAGES)) ? REG_W'(MAX_PAGES) : page_count_ff;
   assign req_page = req.address[ADDR_W-1:PAGE_SHIFT];
   assign end_sum  = {2'b00, req.address} + {2'b00, req.length_bytes}
                     + (ADDR_W+2)'(PAGE_BYTES - 1);
   assign end_page = end_sum[ADDR_W+1:PAGE_SHIFT];

   assign widx    = p_ff[BIT_IDX_W +: WORD_IDX_W];
   assign bidx    = p_ff[BIT_IDX_W-1:0];
   assign cur_bit = wbuf_ff[bidx];
   assign in_win  = (bend_ff > bstart_ff) && ({7'd0, p_ff} >= {14'd0, bstart_ff})
                    && ({7'd0, p_ff} < {14'd0, bend_ff});
   assign rem_sum = rem_ff + PAGE_BYTES_X;
   // a boundary below one page can never hold a page
   assign bnd_ok  = (bnd_ff == '0) || (({1'b0, bnd_ff} >= PAGE_BYTES_X)
                    && (rem_sum <= {1'b0, bnd_ff}));
   assign misaligned = (addr_ff[PAGE_SHIFT-1:0] != '0);
   assign p_next  = {1'b0, p_ff} + 1'b1;

   always_comb begin
      sts.skip = 1'b0;
      case (func_ff)
         FUNC_ALLOC:       sts.skip = (p_ff >= PAGE_W'(lim_ff));
         FUNC_ALLOC_BELOW: sts.skip = (addr_ff == '0) || (p_ff >= PAGE_W'(lim_ff));
         FUNC_FREE:        sts.skip = misaligned || (p_ff >= PAGE_W'(n));
         FUNC_RESERVE,
         FUNC_RELEASE:     sts.skip = (p_ff >= PAGE_W'(lim_ff));
         default:          sts.skip = 1'b1;
      endcase
   end

   always_comb begin
      lim_in    = lim_ff;
      p_in      = p_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      paddr_in  = paddr_ff;
      wbuf_in   = wbuf_ff;
      used_in   = used_ff;
      sts.stop     = 1'b0;
      sts.word_end = 1'b0;
      if (cmd.load) begin
         rem_in   = '0;
         paddr_in = '0;
         case (req.func)
            FUNC_ALLOC: begin
               p_in   = '0;
               lim_in = n;
            end
            FUNC_ALLOC_BELOW: begin
               p_in   = '0;
               lim_in = (req_page > PAGE_W'(n)) ? n : REG_W'(req_page);
            end
            FUNC_FREE: begin
               p_in   = req_page;
               lim_in = REG_W'(req_page) + 1'b1;
            end
            default: begin
               p_in   = req_page;
               lim_in = (end_page > (ADDR_W+2-PAGE_SHIFT)'(n)) ? n : REG_W'(end_page);
            end
         endcase
      end
      if (cmd.check) begin
         case (func_ff)
            FUNC_ALLOC:       status_in = ST_NO_MEMORY;
            FUNC_ALLOC_BELOW: status_in = (addr_ff == '0) ? ST_ZERO_LIMIT : ST_NO_MEMORY;
            FUNC_FREE: begin
               if (misaligned)                status_in = ST_MISALIGNED;
               else if (p_ff >= PAGE_W'(n))   status_in = ST_OUT_RANGE;
               else                           status_in = ST_OK;
            end
            default: status_in = ST_OK;
         endcase
      end
      if (cmd.cap)
         wbuf_in = rvalid_ff ? rdata_ff
                 : ((widx == '0) ? WORD_BITS'(1) : '0);
      if (cmd.step) begin
         sts.stop     = (p_next >= (PAGE_W+1)'(lim_ff));
         sts.word_end = (bidx == '1);
         case (func_ff)
            FUNC_ALLOC: begin
               if (!cur_bit) begin
                  wbuf_in[bidx] = 1'b1;
                  if (used_ff != '1) used_in = used_ff + 1'b1;
                  if (!in_win) begin
                     status_in = ST_OK;
                     paddr_in  = {p_ff, {PAGE_SHIFT{1'b0}}};
                     sts.stop  = 1'b1;
                  end
               end
            end
            FUNC_ALLOC_BELOW: begin
               rem_in = (rem_sum >= {1'b0, bnd_ff}) ? rem_sum - {1'b0, bnd_ff} : rem_sum;
               if (!cur_bit && bnd_ok) begin
                  wbuf_in[bidx] = 1'b1;
                  if (used_ff != '1) used_in = used_ff + 1'b1;
                  status_in = ST_OK;
                  paddr_in  = {p_ff, {PAGE_SHIFT{1'b0}}};
                  sts.stop  = 1'b1;
               end
            end
            FUNC_FREE: begin
               sts.stop = 1'b1;
               if (cur_bit) begin
                  wbuf_in[bidx] = 1'b0;
                  if (used_ff != '0) used_in = used_ff - 1'b1;
               end else begin
                  status_in = ST_DOUBLE_FREE;
               end
            end
            FUNC_RESERVE: begin
               if (!cur_bit) begin
                  wbuf_in[bidx] = 1'b1;
                  if (used_ff != '1) used_in = used_ff + 1'b1;
               end
            end
            FUNC_RELEASE: begin
               if (cur_bit) begin
                  wbuf_in[bidx] = 1'b0;
                  if (used_ff != '0) used_in = used_ff - 1'b1;
               end
            end
            default: sts.stop = 1'b1;
         endcase
         if (!sts.stop) p_in = p_next[PAGE_W-1:0];
      end
   end

   // write back goes to the word that was read; the walker may already be on the next
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff  <= mem[widx];
         rvalid_ff <= valid_ff[widx];
         wa_ff     <= widx;
      end
      if (cmd.wb)
         mem[wa_ff] <= wbuf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         used_ff       <= REG_W'(1);
         page_count_ff <= REG_W'(MAX_PAGES);
         bstart_ff     <= '0;
         bend_ff       <= '0;
         func_ff       <= '0;
      end else begin
         if (cmd.wb) valid_ff[wa_ff] <= 1'b1;
         used_ff <= used_in;
         if (cmd.load) func_ff <= req.func;
         if (csr_valid) begin
            case (csr_index)
               CSR_PAGE_COUNT:   page_count_ff <= csr_data;
               CSR_BUNDLE_START: bstart_ff     <= csr_data;
               CSR_BUNDLE_END:   bend_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req.address;
         bnd_ff  <= req.boundary_bytes;
      end
      p_ff      <= p_in;
      lim_ff    <= lim_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      paddr_ff  <= paddr_in;
      wbuf_ff   <= wbuf_in;
   end

   assign rsp_data.status       = status_ff;
   assign rsp_data.page_address = paddr_ff;
   assign rsp_data.used_pages   = used_ff;
   assign rsp_data.free_pages   = (n > used_ff) ? n - used_ff : '0;

endmodule

// File: rtl/bitmap_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// Bitmap physical page allocator with used-page count and range commands.
// ----------------------------------------------------------------------------
// One request at a time: taken when start is high and busy low, answered by
// a one-cycle rsp_valid strobe that cannot be held off. The walk over the
// bitmap store steps one page per cycle within each 32-page word, and each
// word touched adds a read, a capture and a write back. Rejected requests
// skip the walk and go from the check straight to the response.
module bitmap_page_frame_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpfa_pkg::req_type req,
   output logic              rsp_valid,
   output bpfa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [bpfa_pkg::REG_W-1:0] csr_data
);
   import bpfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   bpfa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = cmd.rsp;
   assign csr_ready = 1'b1;

endmodule

// File: tb/tb_bitmap_page_frame_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator_core
// Self-checking bench for the page frame allocator. A driver feeds requests
// and register writes from a queue, and a monitor predicts every response
// from its own bitmap model and checks it against the core.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator_core;
   import bpfa_pkg::*;

   typedef struct {
      bit          is_csr;
      req_type     rq;
      logic [1:0]  idx;
      logic [12:0] val;
      int          idle_pct;
   } pending_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PAGE_COUNT;
   logic [12:0] csr_data = '0;

   pending_type pending_q[$];
   rsp_type     expected_q[$];
   int          errors = 0;
   int          quiet = 0;
   logic        req_taken = 0;
   logic        csr_taken = 0;

   // model state
   bit [MAX_PAGES-1:0] pg_used;
   int                 used_n;
   int                 cfg_pages, cfg_bstart, cfg_bend;

   bitmap_page_frame_allocator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic void take_page(int p);
      pg_used[p] = 1'b1;
      if (used_n < 8191) used_n++;
   endfunction

   function automatic void drop_page(int p);
      pg_used[p] = 1'b0;
      if (used_n > 0) used_n--;
   endfunction

   function automatic rsp_type allocate_page(req_type r);
      rsp_type     o;
      int          n, maxp, endp;
      bit          window, found;
      longint      phys, bnd;
      o = '0;
      n = (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
      bnd = longint'(r.boundary_bytes);
      case (r.func)
         FUNC_ALLOC: begin
            window = cfg_bend > cfg_bstart;
            o.status = ST_NO_MEMORY;
            found = 0;
            for (int p = 0; p < n && !found; p++) begin
               if (!pg_used[p]) begin
                  take_page(p);
                  if (!(window && p >= cfg_bstart && p < cfg_bend)) begin
                     o.status = ST_OK;
                     o.page_address = p * PAGE_BYTES;
                     found = 1;
                  end
               end
            end
         end
         FUNC_ALLOC_BELOW: begin
            if (r.address == 0) o.status = ST_ZERO_LIMIT;
            else begin
               maxp = r.address / PAGE_BYTES;
               if (maxp > n) maxp = n;
               o.status = ST_NO_MEMORY;
               found = 0;
               for (int p = 0; p < maxp && !found; p++) begin
                  phys = longint'(p) * PAGE_BYTES;
                  if (!pg_used[p] && !(bnd != 0 && (phys % bnd) + PAGE_BYTES > bnd)) begin
                     take_page(p);
                     o.status = ST_OK;
                     o.page_address = phys[31:0];
                     found = 1;
                  end
               end
            end
         end
         FUNC_FREE: begin
            if (r.address % PAGE_BYTES != 0) o.status = ST_MISALIGNED;
            else if (r.address / PAGE_BYTES >= n) o.status = ST_OUT_RANGE;
            else if (!pg_used[r.address / PAGE_BYTES]) o.status = ST_DOUBLE_FREE;
            else drop_page(r.address / PAGE_BYTES);
         end
         FUNC_RESERVE, FUNC_RELEASE: begin
            phys = (longint'(r.address) + longint'(r.length_bytes) + PAGE_BYTES - 1)
                   / PAGE_BYTES;
            endp = (phys > n) ? n : int'(phys);
            for (int p = int'(r.address / PAGE_BYTES); p < endp; p++) begin
               if (r.func == FUNC_RESERVE && !pg_used[p]) take_page(p);
               else if (r.func == FUNC_RELEASE && pg_used[p]) drop_page(p);
            end
         end
         default: ;
      endcase
      o.used_pages = used_n[12:0];
      o.free_pages = (n > used_n) ? 13'(n - used_n) : '0;
      return o;
   endfunction

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pg_used = '0;
         pg_used[0] = 1'b1;
         used_n = 1;
         cfg_pages = 4096;
         cfg_bstart = 0;
         cfg_bend = 0;
         req_taken <= 0;
         csr_taken <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request outstanding: %p", $time, rsp_data);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.status !== e.status) begin
                  $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.page_address !== e.page_address) begin
                  $display("%0t: page_address exp %h got %h", $time, e.page_address,
                           rsp_data.page_address);
                  errors++;
               end
               if (rsp_data.used_pages !== e.used_pages) begin
                  $display("%0t: used_pages exp %0d got %0d", $time, e.used_pages,
                           rsp_data.used_pages);
                  errors++;
               end
               if (rsp_data.free_pages !== e.free_pages) begin
                  $display("%0t: free_pages exp %0d got %0d", $time, e.free_pages,
                           rsp_data.free_pages);
                  errors++;
               end
            end
         end
         if (start && !busy) expected_q.push_back(allocate_page(req));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAGE_COUNT:   cfg_pages = csr_data;
               CSR_BUNDLE_START: cfg_bstart = csr_data;
               CSR_BUNDLE_END:   cfg_bend = csr_data;
               default: ;
            endcase
         end
         req_taken <= start && !busy;
         csr_taken <= csr_valid && csr_ready;
         quiet <= (expected_q.size() == 0 && !busy) ? quiet + 1 : 0;
      end
   end

   // driver
   always @(negedge clock) begin
      logic        nx_start, nx_csr;
      pending_type it;
      nx_start = start && !req_taken;
      nx_csr = csr_valid && !csr_taken;
      if (!reset && !nx_start && !nx_csr && pending_q.size() != 0) begin
         it = pending_q[0];
         if (it.is_csr) begin
            // registers only change with the core idle and nothing in flight
            if (quiet >= 4 && !busy && !start) begin
               void'(pending_q.pop_front());
               csr_index <= it.idx;
               csr_data <= it.val;
               nx_csr = 1;
            end
         end else if ($urandom_range(99) >= it.idle_pct) begin
            void'(pending_q.pop_front());
            req <= it.rq;
            nx_start = 1;
         end
      end
      start <= nx_start;
      csr_valid <= nx_csr;
   end

   function automatic void add_req(logic [2:0] f, logic [31:0] a, logic [31:0] l,
                                   logic [31:0] b, int idle);
      pending_type it;
      it.is_csr = 0;
      it.rq.func = f;
      it.rq.address = a;
      it.rq.length_bytes = l;
      it.rq.boundary_bytes = b;
      it.idx = CSR_PAGE_COUNT;
      it.val = '0;
      it.idle_pct = idle;
      pending_q.push_back(it);
   endfunction

   function automatic void add_csr(logic [1:0] i, logic [12:0] v);
      pending_type it;
      it.is_csr = 1;
      it.rq = '0;
      it.idx = i;
      it.val = v;
      it.idle_pct = 0;
      pending_q.push_back(it);
   endfunction

   function automatic logic [31:0] rand_boundary();
      case ($urandom_range(5))
         0, 1: return 0;
         2:    return 32'd1 << $urandom_range(12, 20);
         3:    return $urandom_range(1, 20000);
         4:    return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_random_req(int n, int idle);
      logic [2:0]  f;
      logic [31:0] a, l;
      int          sel, lim;
      lim = (n < 1) ? 1 : n;
      sel = $urandom_range(99);
      if (sel < 35) f = FUNC_ALLOC;
      else if (sel < 50) f = FUNC_ALLOC_BELOW;
      else if (sel < 75) f = FUNC_FREE;
      else if (sel < 85) f = FUNC_RESERVE;
      else if (sel < 96) f = FUNC_RELEASE;
      else f = 3'($urandom_range(5, 7));
      if ($urandom_range(9) == 0) a = $urandom();
      else a = $urandom_range(0, lim) * PAGE_BYTES + (($urandom_range(7) == 0) ?
               $urandom_range(1, PAGE_BYTES - 1) : 0);
      if ($urandom_range(15) == 0) l = $urandom();
      else l = $urandom_range(0, 40 * PAGE_BYTES);
      add_req(f, a, l, rand_boundary(), idle);
   endfunction

   initial begin
      int pc_list[8];
      int pcount, idle, items;
      pc_list = '{64, 200, 4096, 1, 0, 8191, 33, 120};
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 0;

      // directed requests at reset settings
      add_req(FUNC_ALLOC, 0, 0, 0, 0);
      add_req(FUNC_ALLOC_BELOW, 0, 0, 0, 0);
      add_req(FUNC_ALLOC_BELOW, 32'hFFFF_FFFF, 0, 32'h2000, 0);
      add_req(FUNC_ALLOC_BELOW, 32'h3000, 0, 32'h0800, 0);
      add_req(FUNC_ALLOC_BELOW, 32'h1000, 0, 0, 0);
      add_req(FUNC_FREE, 32'h1001, 0, 0, 0);
      add_req(FUNC_FREE, 32'hFFFF_F000, 0, 0, 0);
      add_req(FUNC_FREE, 32'h0000_5000, 0, 0, 0);
      add_req(FUNC_FREE, 32'h0000_1000, 0, 0, 0);
      add_req(FUNC_RESERVE, 32'h0000_8000, 32'h0000_4000, 0, 0);
      add_req(FUNC_RELEASE, 32'h0000_9000, 32'h0000_0001, 0, 0);
      add_req(FUNC_RESERVE, 32'h0000_3000, 0, 0, 0);
      add_req(FUNC_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      add_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      add_req(3'd6, 0, 0, 0, 0);
      add_req(3'd7, 32'h1000, 32'h1000, 0, 0);
      // tiny pool of 8 pages with a bundle window over pages 1 to 3
      add_csr(CSR_PAGE_COUNT, 8);
      add_csr(CSR_BUNDLE_START, 1);
      add_csr(CSR_BUNDLE_END, 4);
      add_req(FUNC_RELEASE, 0, 32'hFFFF_FFFF, 0, 0);
      add_req(FUNC_ALLOC, 0, 0, 0, 0);
      add_req(FUNC_RESERVE, 0, 32'h8000, 0, 0);
      add_req(FUNC_ALLOC, 0, 0, 0, 0);
      add_req(FUNC_RELEASE, 0, 32'h8000, 0, 0);
      add_req(FUNC_RELEASE, 0, 32'h8000, 0, 0);
      add_req(FUNC_FREE, 0, 0, 0, 0);

      for (int ph = 0; ph < 8; ph++) begin
         pcount = pc_list[ph];
         idle = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 36 : 0;
         items = (pcount >= 4096) ? 60 : 230;
         add_csr(CSR_PAGE_COUNT, 13'(pcount));
         if (ph == 5) begin
            add_csr(CSR_BUNDLE_START, 13'd4096);
            add_csr(CSR_BUNDLE_END, 13'd8191);
         end else if (ph == 6) begin
            add_csr(CSR_BUNDLE_START, 13'd20);
            add_csr(CSR_BUNDLE_END, 13'd5);
         end else begin
            add_csr(CSR_BUNDLE_START, 13'($urandom_range(0, 40)));
            add_csr(CSR_BUNDLE_END, 13'($urandom_range(0, 80)));
         end
         for (int k = 0; k < items; k++) begin
            // stretches without idling inside idling phases too
            add_random_req((pcount > 4096) ? 4096 : pcount,
                           ((k / 30) % 3 == 2) ? 0 : idle);
            if ($urandom_range(40) == 0) add_req(FUNC_RELEASE, 0, 32'hFFFF_FFFF, 0, idle);
         end
      end

      wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #500_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/bpfa_pkg.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dpath.sv
rtl/bitmap_page_frame_allocator_core.sv
tb/tb_bitmap_page_frame_allocator_core.sv
